// ===== rtl/core/kjip_pkg.sv =====
// Package for the keyboard matrix and joystick input port.
// Holds the command codes, stick line numbers, item and read-path types.
// No dependencies.
package kjip_pkg;

   localparam int KEY_ROWS       = 8;
   localparam int KEY_COLS       = 8;
   localparam int STICKS         = 2;
   localparam int STICK_LINES    = 5;
   localparam int REQ_DATA_WIDTH = 24;
   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [2:0] {
      CMD_SET_KEY    = 3'd0,
      CMD_SET_STICK  = 3'd1,
      CMD_READ_KEYS  = 3'd2,
      CMD_READ_STICK = 3'd3,
      CMD_CLEAR      = 3'd4
   } kjip_cmd_type;

   localparam logic [2:0] LINE_UP    = 3'd0;
   localparam logic [2:0] LINE_DOWN  = 3'd1;
   localparam logic [2:0] LINE_LEFT  = 3'd2;
   localparam logic [2:0] LINE_RIGHT = 3'd3;
   localparam logic [2:0] LINE_FIRE  = 3'd4;

   // port_byte[2:0] code that selects the left stick on a read
   localparam logic [2:0] LEFT_STICK_SELECT = 3'd1;

   typedef struct packed {
      kjip_cmd_type cmd;
      logic [2:0]   key_row;
      logic [2:0]   key_column;
      logic         is_pressed;
      logic         stick_number;
      logic [2:0]   stick_line;
      logic [7:0]   port_byte;
   } kjip_item_type;

   typedef struct packed {
      logic [KEY_COLS-1:0]    row_bits;
      logic [STICK_LINES-1:0] stick_bits;
   } kjip_read_type;

endpackage

// ===== rtl/core/keyboard_joystick_input_port.sv =====
// Keyboard matrix and joystick input port, top level.
// Instantiates kjip_matrix and kjip_encode; uses kjip_pkg.
//
// One command is accepted per cycle while req_tready is high. A command is
// held in an input register, where it updates the key matrix or stick
// lines, or is encoded into a read byte that lands in the result register.
// A read passes both registers before rsp_tvalid shows; reads stream at one
// per cycle while rsp_tready stays high; set and clear commands produce no
// result. req_tready drops only while a read waits behind an untaken
// result. All state is flip-flops; valid flags and matrix clear at reset.
module keyboard_joystick_input_port #(
   parameter int SCANNED_ROWS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] key_row, [5:3] key_column, [6] is_pressed, [7] stick_number,
   // [10:8] stick_line, [18:11] port_byte, [23:19] zero
   input  logic [23:0] req_tdata,
   // [2:0] command
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data
   output logic [7:0]  rsp_tdata
);

   logic                    s1_valid_ff, s1_valid_in;
   kjip_pkg::kjip_item_type s1_item_ff, s1_item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;

   kjip_pkg::kjip_read_type rd;
   logic                    is_read;
   logic [7:0]              read_data;
   logic                    out_free;
   logic                    s1_go;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!is_read || out_free);
   assign req_tready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_tready) begin
         s1_valid_in             = req_tvalid;
         s1_item_in.cmd          = kjip_pkg::kjip_cmd_type'(req_tuser);
         s1_item_in.key_row      = req_tdata[2:0];
         s1_item_in.key_column   = req_tdata[5:3];
         s1_item_in.is_pressed   = req_tdata[6];
         s1_item_in.stick_number = req_tdata[7];
         s1_item_in.stick_line   = req_tdata[10:8];
         s1_item_in.port_byte    = req_tdata[18:11];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go && is_read) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = read_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   kjip_matrix u_matrix (
      .clock (clock),
      .reset (reset),
      .apply (s1_go),
      .item  (s1_item_ff),
      .rd    (rd)
   );

   kjip_encode #(
      .SCANNED_ROWS (SCANNED_ROWS)
   ) u_encode (
      .item      (s1_item_ff),
      .rd        (rd),
      .is_read   (is_read),
      .read_data (read_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/kjip_matrix.sv =====
// Key matrix and joystick line registers with set, release and clear.
// Also selects the row and stick addressed by a read. Uses kjip_pkg.
module kjip_matrix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    apply,
   input  kjip_pkg::kjip_item_type item,
   output kjip_pkg::kjip_read_type rd
);

   logic [kjip_pkg::KEY_COLS-1:0]    key_ff   [kjip_pkg::KEY_ROWS];
   logic [kjip_pkg::KEY_COLS-1:0]    key_in   [kjip_pkg::KEY_ROWS];
   logic [kjip_pkg::STICK_LINES-1:0] stick_ff [kjip_pkg::STICKS];
   logic [kjip_pkg::STICK_LINES-1:0] stick_in [kjip_pkg::STICKS];

   always_comb begin
      key_in   = key_ff;
      stick_in = stick_ff;
      if (apply) begin
         unique case (item.cmd)
            kjip_pkg::CMD_SET_KEY: begin
               key_in[item.key_row][item.key_column] = item.is_pressed;
            end
            kjip_pkg::CMD_SET_STICK: begin
               // unused line codes leave the sticks alone
               if (item.stick_line < 3'(kjip_pkg::STICK_LINES)) begin
                  stick_in[item.stick_number][item.stick_line] = item.is_pressed;
               end
            end
            kjip_pkg::CMD_CLEAR: begin
               key_in   = '{default: '0};
               stick_in = '{default: '0};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '{default: '0};
         stick_ff <= '{default: '0};
      end else begin
         key_ff   <= key_in;
         stick_ff <= stick_in;
      end
   end

   always_comb begin
      rd.row_bits   = key_ff[item.port_byte[2:0]];
      rd.stick_bits = (item.port_byte[2:0] == kjip_pkg::LEFT_STICK_SELECT) ?
                      stick_ff[0] : stick_ff[1];
   end

endmodule

// ===== rtl/core/kjip_encode.sv =====
// Read encoder: lowest pressed column of the scanned row, or active-low stick.
// Combinational only. Uses kjip_pkg.
module kjip_encode #(
   parameter int SCANNED_ROWS = 6
) (
   input  kjip_pkg::kjip_item_type item,
   input  kjip_pkg::kjip_read_type rd,
   output logic                    is_read,
   output logic [7:0]              read_data
);

   logic       hit;
   logic [2:0] col;
   logic       scanned;
   logic [7:0] key_byte;
   logic [7:0] stick_byte;

   always_comb begin
      hit = 1'b0;
      col = 3'd0;
      for (int c = kjip_pkg::KEY_COLS - 1; c >= 0; c--) begin
         if (rd.row_bits[c]) begin
            hit = 1'b1;
            col = 3'(c);
         end
      end
   end

   assign scanned  = {1'b0, item.port_byte[2:0]} < 4'(SCANNED_ROWS);
   assign key_byte = (scanned && hit) ?
                     {col ^ 3'd7, 1'b0, item.port_byte[3:0]} :
                     (item.port_byte | 8'hF0);

   assign stick_byte = {3'b111,
                        ~rd.stick_bits[kjip_pkg::LINE_FIRE],
                        ~rd.stick_bits[kjip_pkg::LINE_LEFT],
                        ~rd.stick_bits[kjip_pkg::LINE_DOWN],
                        ~rd.stick_bits[kjip_pkg::LINE_RIGHT],
                        ~rd.stick_bits[kjip_pkg::LINE_UP]};

   always_comb begin
      unique case (item.cmd)
         kjip_pkg::CMD_READ_KEYS: begin
            is_read   = 1'b1;
            read_data = key_byte;
         end
         kjip_pkg::CMD_READ_STICK: begin
            is_read   = 1'b1;
            read_data = stick_byte;
         end
         default: begin
            is_read   = 1'b0;
            read_data = 8'h00;
         end
      endcase
   end

endmodule

// ===== rtl/core/kjip_checker.sv =====
// Port-level checks for keyboard_joystick_input_port, bound to the top level.
// Sees the top-level ports only. No package dependency.
module kjip_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // no result is pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // input backpressure only while a result is stalled
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without output stall");

endmodule

bind keyboard_joystick_input_port kjip_port_checks u_kjip_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
